>>> hw/rtl/obpt_pkg.sv
// obpt_pkg: shared types, codes and command/status structs for the order book position table
// used by obpt_ctrl, obpt_dpath and order_book_position_table_core; no dependencies
package obpt_pkg;

  // operation codes carried in the input tuser
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_MOD   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_TRADE = 3'd4;
  localparam logic [2:0] OP_INC   = 3'd5;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_RANGE     = 2'd2;
  localparam logic [1:0] STS_CLAMPED   = 2'd3;

  localparam int POS_W = 12;

  // one table entry
  typedef struct packed {
    logic [63:0] order_id;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [7:0]  lot_type;
    logic [7:0]  order_type;
  } entry_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_CLEAR, ST_SEARCH, ST_SWAIT, ST_FOUND,
    ST_DEL_SHIFT, ST_DEL_DRAIN, ST_DEL_ZERO, ST_ADD_SHIFT, ST_ADD_DRAIN,
    ST_ADD_WRITE, ST_UPDATE, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CNT_HOLD, CNT_CLR, CNT_IDX1, CNT_TOP, CNT_INC, CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_ZERO_ALL, WR_SHIFT_UP, WR_SHIFT_DN, WR_ZERO_LAST, WR_NEW, WR_UPD
  } wr_kind_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_OK_POS, RES_NOT_FOUND, RES_RANGE, RES_OK_IDX, RES_CLEAR
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      cap_in;
    logic      rd_en;
    logic      srch;
    logic      res_load;
    cnt_op_t   cnt;
    wr_kind_t  wr;
    res_kind_t res;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       id_zero;
    logic       pos_ok;
    logic       pos_last;
    logic       pos_eq_idx;
    logic       idx_last;
    logic       hit;
    logic       miss;
    logic       trade_zero;
    logic       cnt_last;
    logic       cnt_at_pos;
    logic       out_busy;
  } dp_sts_t;

endpackage

>>> hw/rtl/obpt_ram.sv
// obpt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module obpt_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/obpt_ctrl.sv
// obpt_ctrl: sequencer for search, shift, update and clearing sweeps
// depends on obpt_pkg
module obpt_ctrl import obpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t    state_r, state_nxt;
  res_kind_t res_r, res_nxt;
  logic      mv_r, mv_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      res_r   <= RES_NONE;
      mv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      mv_r    <= mv_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    mv_nxt    = mv_r;
    cmd       = '0;
    cmd.cnt   = CNT_HOLD;
    cmd.wr    = WR_NONE;
    cmd.res   = res_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_INIT: begin
        cmd.wr  = WR_ZERO_ALL;
        cmd.cnt = CNT_INC;
        if (sts.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        mv_nxt = 1'b0;
        unique case (sts.op)
          OP_ADD: begin
            if (!sts.pos_ok) begin
              res_nxt   = RES_RANGE;
              state_nxt = ST_DONE;
            end else begin
              res_nxt   = RES_OK_POS;
              cmd.cnt   = CNT_TOP;
              state_nxt = sts.pos_last ? ST_ADD_WRITE : ST_ADD_SHIFT;
            end
          end
          OP_CLEAR: begin
            res_nxt   = RES_CLEAR;
            cmd.cnt   = CNT_CLR;
            state_nxt = ST_CLEAR;
          end
          OP_DEL, OP_MOD, OP_TRADE, OP_INC: begin
            if (sts.id_zero) begin
              res_nxt   = RES_NOT_FOUND;
              state_nxt = ST_DONE;
            end else begin
              cmd.cnt   = CNT_CLR;
              state_nxt = ST_SEARCH;
            end
          end
          default: begin
            res_nxt   = RES_NONE;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.wr  = WR_ZERO_ALL;
        cmd.cnt = CNT_INC;
        if (sts.cnt_last) state_nxt = ST_DONE;
      end
      ST_SEARCH: begin
        cmd.srch = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_FOUND;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.cnt   = CNT_INC;
          if (sts.cnt_last) state_nxt = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        cmd.srch = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_FOUND;
        end else if (sts.miss) begin
          res_nxt   = RES_NOT_FOUND;
          state_nxt = ST_DONE;
        end
      end
      ST_FOUND: begin
        res_nxt = RES_OK_IDX;
        if (sts.op == OP_INC ||
            (sts.op == OP_TRADE && !sts.trade_zero) ||
            (sts.op == OP_MOD && sts.pos_eq_idx)) begin
          state_nxt = ST_UPDATE;
        end else if (sts.op == OP_MOD && !sts.pos_ok) begin
          res_nxt   = RES_RANGE;
          state_nxt = ST_DONE;
        end else begin
          // remove the entry, a move then reinserts it
          mv_nxt    = (sts.op == OP_MOD);
          cmd.cnt   = CNT_IDX1;
          state_nxt = sts.idx_last ? ST_DEL_ZERO : ST_DEL_SHIFT;
        end
      end
      ST_DEL_SHIFT: begin
        cmd.rd_en = 1'b1;
        cmd.wr    = WR_SHIFT_UP;
        cmd.cnt   = CNT_INC;
        if (sts.cnt_last) state_nxt = ST_DEL_DRAIN;
      end
      ST_DEL_DRAIN: begin
        cmd.wr    = WR_SHIFT_UP;
        state_nxt = ST_DEL_ZERO;
      end
      ST_DEL_ZERO: begin
        cmd.wr = WR_ZERO_LAST;
        if (mv_r) begin
          cmd.cnt   = CNT_TOP;
          state_nxt = sts.pos_last ? ST_ADD_WRITE : ST_ADD_SHIFT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ADD_SHIFT: begin
        cmd.rd_en = 1'b1;
        cmd.wr    = WR_SHIFT_DN;
        cmd.cnt   = CNT_DEC;
        if (sts.cnt_at_pos) state_nxt = ST_ADD_DRAIN;
      end
      ST_ADD_DRAIN: begin
        cmd.wr    = WR_SHIFT_DN;
        state_nxt = ST_ADD_WRITE;
      end
      ST_ADD_WRITE: begin
        cmd.wr    = WR_NEW;
        state_nxt = ST_DONE;
      end
      ST_UPDATE: begin
        cmd.wr    = WR_UPD;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold here while the previous result still waits
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/obpt_dpath.sv
// obpt_dpath: item register, sweep counter, table rams, compare and result register
// depends on obpt_pkg and obpt_ram
module obpt_dpath import obpt_pkg::*; #(
  parameter int BOOK_DEPTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [2:0]             in_op,
  input  logic                   in_side,
  input  logic [63:0]            in_order_id,
  input  logic signed [31:0]     in_price,
  input  logic [31:0]            in_quantity,
  input  logic [7:0]             in_lot_type,
  input  logic [7:0]             in_order_type,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [POS_W-1:0]       out_result_position
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(BOOK_DEPTH - 1);
  localparam logic [AW-1:0] TOP  = AW'(BOOK_DEPTH - 2);

  // captured item
  logic [2:0]       op_r;
  logic             side_r;
  logic [63:0]      id_r;
  logic [31:0]      price_r;
  logic [31:0]      qty_r;
  logic [7:0]       lot_r;
  logic [7:0]       otype_r;
  logic [POS_W-1:0] pos_r;

  logic [AW-1:0] cnt_r, rd_addr_r, idx_r;
  logic          rd_vld_r, hit_r, miss_r, out_valid_r;
  entry_t        hit_ent_r;
  logic [1:0]       status_r;
  logic [POS_W-1:0] rpos_r;

  entry_t        rd_bid, rd_ofr, rd_ent, upd_ent, new_ent, wdata;
  logic          we_bid, we_ofr, clamp, match;
  logic [AW-1:0] waddr, p0;
  logic [POS_W:0] idx1;
  logic [32:0]   qsum;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r    <= in_op;
      side_r  <= in_side;
      id_r    <= in_order_id;
      price_r <= in_price;
      qty_r   <= in_quantity;
      lot_r   <= in_lot_type;
      otype_r <= in_order_type;
      pos_r   <= in_position;
    end
  end

  assign p0   = AW'(pos_r - POS_W'(1));
  assign idx1 = (POS_W + 1)'(idx_r) + (POS_W + 1)'(1);

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (cmd.cnt)
        CNT_CLR:  cnt_r <= '0;
        CNT_IDX1: cnt_r <= idx_r + AW'(1);
        CNT_TOP:  cnt_r <= TOP;
        CNT_INC:  cnt_r <= cnt_r + AW'(1);
        CNT_DEC:  cnt_r <= cnt_r - AW'(1);
        default:  cnt_r <= cnt_r;
      endcase
    end
  end

  // read tracking and search result
  assign rd_ent = side_r ? rd_ofr : rd_bid;
  assign match  = rd_vld_r && (rd_ent.order_id == id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      miss_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.cap_in) begin
        hit_r  <= 1'b0;
        miss_r <= 1'b0;
      end else if (cmd.srch && !hit_r && !miss_r) begin
        if (match) hit_r <= 1'b1;
        else if (rd_vld_r && rd_addr_r == LAST) miss_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_addr_r <= cnt_r;
    if (cmd.srch && !hit_r && !miss_r && match) begin
      idx_r     <= rd_addr_r;
      hit_ent_r <= rd_ent;
    end
  end

  // modified entry for update, trade, increase and move
  assign qsum  = {1'b0, hit_ent_r.quantity} + {1'b0, qty_r};
  assign clamp = qty_r > hit_ent_r.quantity;
  always_comb begin
    upd_ent = hit_ent_r;
    case (op_r)
      OP_MOD: begin
        upd_ent.price      = price_r;
        upd_ent.quantity   = qty_r;
        upd_ent.order_type = otype_r;
      end
      OP_TRADE: upd_ent.quantity = clamp ? 32'd0 : hit_ent_r.quantity - qty_r;
      OP_INC:   upd_ent.quantity = qsum[32] ? 32'hFFFF_FFFF : qsum[31:0];
      default:  upd_ent = hit_ent_r;
    endcase
  end

  always_comb begin
    if (op_r == OP_ADD) begin
      new_ent = '{order_id: id_r, price: price_r, quantity: qty_r,
                  lot_type: lot_r, order_type: otype_r};
    end else begin
      new_ent = upd_ent;
    end
  end

  // table write port
  always_comb begin
    we_bid = 1'b0;
    we_ofr = 1'b0;
    waddr  = cnt_r;
    wdata  = '0;
    case (cmd.wr)
      WR_ZERO_ALL: begin
        we_bid = 1'b1;
        we_ofr = 1'b1;
      end
      WR_SHIFT_UP: begin
        we_bid = rd_vld_r && !side_r;
        we_ofr = rd_vld_r && side_r;
        waddr  = rd_addr_r - AW'(1);
        wdata  = rd_ent;
      end
      WR_SHIFT_DN: begin
        we_bid = rd_vld_r && !side_r;
        we_ofr = rd_vld_r && side_r;
        waddr  = rd_addr_r + AW'(1);
        wdata  = rd_ent;
      end
      WR_ZERO_LAST: begin
        we_bid = !side_r;
        we_ofr = side_r;
        waddr  = LAST;
      end
      WR_NEW: begin
        we_bid = !side_r;
        we_ofr = side_r;
        waddr  = p0;
        wdata  = new_ent;
      end
      WR_UPD: begin
        we_bid = !side_r;
        we_ofr = side_r;
        waddr  = idx_r;
        wdata  = upd_ent;
      end
      default: we_bid = 1'b0;
    endcase
  end

  obpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk   (clk),
    .we    (we_bid),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en && !side_r),
    .raddr (cnt_r),
    .rdata (rd_bid)
  );

  obpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(BOOK_DEPTH)) u_ofr_ram (
    .clk   (clk),
    .we    (we_ofr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en && side_r),
    .raddr (cnt_r),
    .rdata (rd_ofr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res)
        RES_OK_POS: begin
          status_r <= STS_OK;
          rpos_r   <= pos_r;
        end
        RES_NOT_FOUND: begin
          status_r <= STS_NOT_FOUND;
          rpos_r   <= '0;
        end
        RES_RANGE: begin
          status_r <= STS_RANGE;
          rpos_r   <= '0;
        end
        RES_OK_IDX: begin
          status_r <= (op_r == OP_TRADE && clamp) ? STS_CLAMPED : STS_OK;
          rpos_r   <= idx1[POS_W-1:0];
        end
        RES_CLEAR: begin
          status_r <= STS_OK;
          rpos_r   <= POS_W'(1);
        end
        default: begin
          status_r <= STS_OK;
          rpos_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_result_position = rpos_r;

  // status towards the controller
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.id_zero    = (id_r == 64'd0);
    sts.pos_ok     = (pos_r != '0) && ({1'b0, pos_r} <= (POS_W + 1)'(BOOK_DEPTH));
    sts.pos_last   = (p0 == LAST);
    sts.pos_eq_idx = ({1'b0, pos_r} == idx1);
    sts.idx_last   = (idx_r == LAST);
    sts.hit        = hit_r;
    sts.miss       = miss_r;
    sts.trade_zero = (upd_ent.quantity == 32'd0);
    sts.cnt_last   = (cnt_r == LAST);
    sts.cnt_at_pos = (cnt_r == p0);
    sts.out_busy   = out_valid_r;
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !out_valid_r) else $error("result loaded over a waiting one");
  a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_r && miss_r)) else $error("search both hit and missed");
  a_cap_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_in |=> !hit_r && !miss_r) else $error("search flags not cleared");
`endif

endmodule

>>> hw/rtl/order_book_position_table_core.sv
// order_book_position_table_core: top level of the bid/offer position table
// depends on obpt_pkg, obpt_ctrl, obpt_dpath and obpt_ram
//
//  channel | direction | contents
//  in_     | slave     | tuser op, side; tdata id, price, quantity, lot, type, position
//  out_    | master    | tuser status; tdata result_position
//
// one item at a time; id operations scan the table one ram read a cycle, and a delete or
// move then shifts the tail one entry a cycle, set by the single read port of each table ram.
// after reset a clearing pass over all BOOK_DEPTH entries runs before the first input transfer.
// a waiting result holds the next item in its last step until out_tready takes it.
module order_book_position_table_core import obpt_pkg::*; #(
  parameter int BOOK_DEPTH = 2048
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,  // order_id, price, quantity, lot_type, order_type, position
  input  logic [3:0]   in_tuser,  // op, side
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata, // result_position
  output logic [1:0]   out_tuser  // status
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [POS_W-1:0] rpos;

  obpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  obpt_dpath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_tuser[2:0]),
    .in_side             (in_tuser[3]),
    .in_order_id         (in_tdata[63:0]),
    .in_price            (in_tdata[95:64]),
    .in_quantity         (in_tdata[127:96]),
    .in_lot_type         (in_tdata[135:128]),
    .in_order_type       (in_tdata[143:136]),
    .in_position         (in_tdata[155:144]),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_status          (out_tuser),
    .out_result_position (rpos)
  );

  assign out_tdata = {4'd0, rpos};

endmodule
